@@ rtl/core/lcpid_pkg.sv @@
// Shared types, constants and the microcode ROM of the load current regulator.
`default_nettype none

package lcpid_pkg;

    // Default build parameters
    localparam int ADC_BITS_DEF    = 12;
    localparam int INTEG_WIDTH_DEF = 24;

    // Output level saturation, Q2.14 volts (3.3 V)
    localparam int LEVEL_MAX = 54067;

    // ADC scaling: amps = ((code + 1) * 270336 + 5 * full) / (10 * full)
    // 270336 = 2^18 + 2^13, so the scale is two shifts and an add
    localparam int AMPS_W      = 15;   // quotient width, amps stay below 2^15
    localparam int SCALE_SH_HI = 18;
    localparam int SCALE_SH_LO = 13;

    // Setpoint to Q3.13: floor((sp * 8192 + 50) / 100) via reciprocal
    localparam int               SP_X_W     = 21;
    localparam int               SP_FRAC    = 13;
    localparam logic [SP_X_W-1:0] SP_HALF   = 21'd50;
    localparam int               SP_RECIP_W = 22;
    localparam logic [SP_RECIP_W-1:0] SP_RECIP = 22'd2684355;  // ceil(2^28 / 100)
    localparam int               SP_SHIFT   = 28;

    // Q.29 to Q2.14 rounding, half up
    localparam int ROUND_SH   = 15;
    localparam int ROUND_HALF = 16384;

    // Integral dropout threshold, -2 A in Q3.13
    localparam int DROPOUT_LIMIT = -16384;

    // Register reset values
    localparam logic [15:0] GAIN_PROP_RST    = 16'd3277;
    localparam logic [15:0] GAIN_INTEG_RST   = 16'd164;
    localparam logic [15:0] GAIN_DERIV_RST   = 16'd328;
    localparam logic [15:0] OVER_LIMIT_RST   = 16'd9830;
    localparam logic [15:0] SAFE_LEVEL_RST   = 16'd3768;
    localparam logic [9:0]  RAMP_STEP_RST    = 10'd33;
    localparam logic [15:0] RAMP_CEILING_RST = 16'd16384;
    localparam logic [7:0]  SETPOINT_MAX_RST = 8'd150;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_GAIN_PROP,
        CFG_GAIN_INTEG,
        CFG_GAIN_DERIV,
        CFG_OVER_LIMIT,
        CFG_SAFE_LEVEL,
        CFG_RAMP_STEP,
        CFG_RAMP_CEILING,
        CFG_SETPOINT_MAX
    } t_cfg_idx;

    // Micro-operations driving the datapath
    typedef enum logic [3:0] {
        UOP_DIV,     // reciprocal estimate of the ADC scaling quotient
        UOP_DIVFIX,  // pull the estimate down by one where it overshoots
        UOP_SPMUL,   // setpoint times reciprocal
        UOP_EVAL,    // overcurrent, ramp, error and integral
        UOP_MUL_P,   // error times proportional gain
        UOP_MUL_I,   // integral times integral gain
        UOP_MUL_D,   // error difference times derivative gain
        UOP_ACC,     // last accumulate
        UOP_FIN,     // new level, rounding, clamp, dropout
        UOP_OUT      // hand result to output register
    } t_uop;

    // Jump conditions; taken goes to target, otherwise pc + 1
    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_NOPID,   // this pass runs no PID update
        JMP_WAIT     // output register still full
    } t_jmp;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_upc;

    localparam t_upc PC_DIV    = 4'd0;
    localparam t_upc PC_DIVFIX = 4'd1;
    localparam t_upc PC_SPMUL  = 4'd2;
    localparam t_upc PC_EVAL   = 4'd3;
    localparam t_upc PC_MUL_P  = 4'd4;
    localparam t_upc PC_MUL_I  = 4'd5;
    localparam t_upc PC_MUL_D  = 4'd6;
    localparam t_upc PC_ACC    = 4'd7;
    localparam t_upc PC_FIN    = 4'd8;
    localparam t_upc PC_OUT    = 4'd9;

    typedef struct packed {
        t_uop op;
        t_jmp jmp;
        t_upc target;
    } t_uword;

    // Microcode ROM
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            PC_DIV:    w = '{op: UOP_DIV,    jmp: JMP_NONE,  target: PC_DIVFIX};
            PC_DIVFIX: w = '{op: UOP_DIVFIX, jmp: JMP_NONE,  target: PC_SPMUL};
            PC_SPMUL:  w = '{op: UOP_SPMUL,  jmp: JMP_NONE,  target: PC_EVAL};
            PC_EVAL:   w = '{op: UOP_EVAL,   jmp: JMP_NOPID, target: PC_OUT};
            PC_MUL_P:  w = '{op: UOP_MUL_P,  jmp: JMP_NONE,  target: PC_MUL_I};
            PC_MUL_I:  w = '{op: UOP_MUL_I,  jmp: JMP_NONE,  target: PC_MUL_D};
            PC_MUL_D:  w = '{op: UOP_MUL_D,  jmp: JMP_NONE,  target: PC_ACC};
            PC_ACC:    w = '{op: UOP_ACC,    jmp: JMP_NONE,  target: PC_FIN};
            PC_FIN:    w = '{op: UOP_FIN,    jmp: JMP_NONE,  target: PC_OUT};
            PC_OUT:    w = '{op: UOP_OUT,    jmp: JMP_WAIT,  target: PC_OUT};
            default:   w = '{op: UOP_OUT,    jmp: JMP_WAIT,  target: PC_OUT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/load_current_pid_regulator_core.sv @@
// Top level of the load current regulator: microcoded sequencer and datapath.
`default_nettype none

// Load current PID regulator. Each input item is one pass of the control loop:
// a raw ADC current sample, the plus and minus setpoint buttons and the 100 ms
// tick; each item gives exactly one result item (drive level, setpoint,
// regulating flag, overcurrent flag). The ADC sample is scaled to Q3.13 amps by
// a reciprocal multiplication and a one-step correction, the setpoint is
// scaled by one pass of the shared multiplier, and a PID update uses the same
// multiplier three more times. A pass without PID update skips from the
// evaluate step to the output step; a pass with PID update also runs the
// multiply, accumulate and final steps. One item is in work at a time. The
// output register holds a finished result while the next item is accepted;
// only if that result is still untaken when the next one finishes does the
// sequencer wait. Configuration writes are always ready and are to be made
// only while the block is idle.
module load_current_pid_regulator_core #(
    parameter int ADC_BITS    = lcpid_pkg::ADC_BITS_DEF,
    parameter int INTEG_WIDTH = lcpid_pkg::INTEG_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write channel
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [15:0]         i_cfg_data,
    // input item channel
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ADC_BITS-1:0] i_current_code,
    input  wire logic                i_plus_press,
    input  wire logic                i_minus_press,
    input  wire logic                i_tick,
    // result item channel
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [15:0]              o_drive_level,
    output logic [7:0]               o_setpoint_now,
    output logic                     o_regulating,
    output logic                     o_overcurrent
);

    // ---------------------------------------------------------------------
    // Derived widths
    // ---------------------------------------------------------------------
    localparam int AMPS_W  = lcpid_pkg::AMPS_W;
    localparam int ERR_W   = AMPS_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int DIV_W   = ADC_BITS + 4;             // holds 10 * full
    localparam int NUM_W   = ADC_BITS + 19;            // scaled dividend
    localparam int MUL_A_W = (INTEG_WIDTH > lcpid_pkg::SP_X_W) ?
                             INTEG_WIDTH : lcpid_pkg::SP_X_W + 1;
    localparam int MUL_B_W = lcpid_pkg::SP_RECIP_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
    localparam int ACC_W   = INTEG_WIDTH + 19;
    localparam int LVL_W   = ACC_W + 1;

    // reciprocal of 10 * full, rounded up, scaled by 2^NUM_W: the estimate is
    // the true quotient or one above it
    localparam longint DIVISOR_L = 10 * ((longint'(1) << ADC_BITS) - 1);
    localparam longint RECIP_L   = ((longint'(1) << NUM_W) + DIVISOR_L - 1) / DIVISOR_L;
    localparam int     RECIP_W   = $clog2(RECIP_L + 1);
    localparam int     RCP_W     = NUM_W + RECIP_W;

    localparam logic [DIV_W-1:0]   DIVISOR  = DIV_W'(DIVISOR_L);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_L);
    localparam logic [NUM_W-1:0]   NUM_BIAS = NUM_W'(5 * ((1 << ADC_BITS) - 1));
    localparam logic [15:0]        LVL_MAX  = 16'(lcpid_pkg::LEVEL_MAX);
    localparam logic signed [INTEG_WIDTH-1:0] DROP_LIM =
        INTEG_WIDTH'(lcpid_pkg::DROPOUT_LIMIT);

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    // configuration
    logic [15:0] r_gain_prop, r_gain_integ, r_gain_deriv, r_over_limit;
    logic [15:0] r_safe_level, r_ramp_ceiling;
    logic [9:0]  r_ramp_step;
    logic [7:0]  r_setpoint_max;

    // loop state
    logic [15:0]                    r_level;
    logic [7:0]                     r_setpoint;
    logic                           r_active;
    logic signed [INTEG_WIDTH-1:0]  r_integ;
    logic signed [ERR_W-1:0]        r_last_err;
    logic                           r_pending;

    // sequencer
    logic                    r_busy;
    lcpid_pkg::t_upc         r_pc;
    logic                    r_out_valid;

    // datapath scratch
    logic [NUM_W-1:0]           r_num;
    logic [AMPS_W-1:0]          r_quo;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ERR_W-1:0]    r_prev;
    logic                       r_over;
    logic [15:0]                r_out_level;
    logic [7:0]                 r_out_setpoint;
    logic                       r_out_active;
    logic                       r_out_over;

    // ---------------------------------------------------------------------
    // Microcode fetch
    // ---------------------------------------------------------------------
    lcpid_pkg::t_uword uw;

    assign uw = lcpid_pkg::ucode(r_pc);

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    logic in_acc, out_busy, out_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy;
    assign in_acc      = i_in_valid && !r_busy;
    assign out_busy    = r_out_valid && !i_out_ready;
    assign out_load    = r_busy && (uw.op == lcpid_pkg::UOP_OUT) && !out_busy;

    assign o_out_valid    = r_out_valid;
    assign o_drive_level  = r_out_level;
    assign o_setpoint_now = r_out_setpoint;
    assign o_regulating   = r_out_active;
    assign o_overcurrent  = r_out_over;

    // ---------------------------------------------------------------------
    // Item intake: setpoint buttons (plus first) and scaled dividend
    // ---------------------------------------------------------------------
    logic [7:0]        sp_plus, sp_next;
    logic [ADC_BITS:0] code_inc;
    logic [NUM_W-1:0]  num;

    always_comb begin
        sp_plus = r_setpoint;
        if (i_plus_press && (r_setpoint <= r_setpoint_max) && (r_setpoint != 8'hFF)) begin
            sp_plus = r_setpoint + 8'd1;
        end
        sp_next = sp_plus;
        if (i_minus_press && (sp_plus > 8'd1)) begin
            sp_next = sp_plus - 8'd1;
        end
    end

    // (code + 1) * 270336 + 5 * full
    assign code_inc = {1'b0, i_current_code} + (ADC_BITS+1)'(1);
    assign num = (NUM_W'(code_inc) << lcpid_pkg::SCALE_SH_HI)
               + (NUM_W'(code_inc) << lcpid_pkg::SCALE_SH_LO)
               + NUM_BIAS;

    // ---------------------------------------------------------------------
    // Divide by 10 * full: reciprocal estimate, then one correction
    // ---------------------------------------------------------------------
    logic [RCP_W-1:0]  rcp_prod;
    logic [AMPS_W-1:0] quo_est;
    logic [NUM_W-1:0]  fix_prod;
    logic [AMPS_W-1:0] quo_fix;

    assign rcp_prod = RCP_W'(r_num) * RCP_W'(RECIP);
    assign quo_est  = rcp_prod[NUM_W +: AMPS_W];
    assign fix_prod = NUM_W'(r_quo) * NUM_W'(DIVISOR);
    assign quo_fix  = (fix_prod > r_num) ? r_quo - AMPS_W'(1) : r_quo;

    // ---------------------------------------------------------------------
    // Shared multiplier
    // ---------------------------------------------------------------------
    lcpid_pkg::t_upc   pc_next;
    logic              taken;
    logic              pid_go;

    logic [lcpid_pkg::SP_X_W-1:0] sp_x;
    logic signed [DIFF_W-1:0]     err_diff;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]           mul_b;
    logic signed [PROD_W-1:0]     mul_p;

    assign sp_x = ({{(lcpid_pkg::SP_X_W-8){1'b0}}, r_setpoint} << lcpid_pkg::SP_FRAC)
                + lcpid_pkg::SP_HALF;
    assign err_diff = DIFF_W'(r_prev) - DIFF_W'(r_last_err);

    always_comb begin
        case (uw.op)
            lcpid_pkg::UOP_SPMUL: begin
                mul_a = MUL_A_W'($signed({1'b0, sp_x}));
                mul_b = lcpid_pkg::SP_RECIP;
            end
            lcpid_pkg::UOP_MUL_P: begin
                mul_a = MUL_A_W'(r_last_err);
                mul_b = MUL_B_W'(r_gain_prop);
            end
            lcpid_pkg::UOP_MUL_I: begin
                mul_a = MUL_A_W'(r_integ);
                mul_b = MUL_B_W'(r_gain_integ);
            end
            lcpid_pkg::UOP_MUL_D: begin
                mul_a = MUL_A_W'(err_diff);
                mul_b = MUL_B_W'(r_gain_deriv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // ---------------------------------------------------------------------
    // Evaluate step: overcurrent, ramp, error and integral
    // ---------------------------------------------------------------------
    logic [AMPS_W-1:0]             amps, sp_q13;
    logic                          over;
    logic [15:0]                   safe_clamp, ramp_clamp;
    logic [16:0]                   ramp_sum;
    logic signed [ERR_W-1:0]       eval_err;
    logic signed [INTEG_WIDTH:0]   integ_sum;
    logic signed [INTEG_WIDTH-1:0] integ_sat;

    assign amps   = r_quo;
    assign sp_q13 = r_prod[lcpid_pkg::SP_SHIFT +: AMPS_W];
    assign over   = {1'b0, amps} > r_over_limit;
    assign pid_go = !over && r_pending && r_active;

    assign safe_clamp = (r_safe_level > LVL_MAX) ? LVL_MAX : r_safe_level;
    assign ramp_sum   = {1'b0, r_level} + 17'(r_ramp_step);
    assign ramp_clamp = (ramp_sum > {1'b0, LVL_MAX}) ? LVL_MAX : ramp_sum[15:0];

    assign eval_err  = $signed({1'b0, amps}) - $signed({1'b0, sp_q13});
    assign integ_sum = (INTEG_WIDTH+1)'(r_integ) + (INTEG_WIDTH+1)'(eval_err);

    // saturate to the signed integral range
    always_comb begin
        if (integ_sum[INTEG_WIDTH] != integ_sum[INTEG_WIDTH-1]) begin
            integ_sat = integ_sum[INTEG_WIDTH] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                               : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
        end else begin
            integ_sat = integ_sum[INTEG_WIDTH-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Final step: level * 2^15 - sum, round half up to Q2.14, clamp
    // ---------------------------------------------------------------------
    logic signed [LVL_W-1:0] fin_y, fin_sh;
    logic [15:0]             fin_level;

    assign fin_y = $signed(LVL_W'({r_level, {lcpid_pkg::ROUND_SH{1'b0}}}))
                 + LVL_W'(lcpid_pkg::ROUND_HALF) - LVL_W'(r_acc);
    assign fin_sh = fin_y >>> lcpid_pkg::ROUND_SH;

    always_comb begin
        if (fin_sh[LVL_W-1]) begin
            fin_level = '0;
        end else if (fin_sh > $signed(LVL_W'(lcpid_pkg::LEVEL_MAX))) begin
            fin_level = LVL_MAX;
        end else begin
            fin_level = fin_sh[15:0];
        end
    end

    // ---------------------------------------------------------------------
    // Next micro-address
    // ---------------------------------------------------------------------
    always_comb begin
        case (uw.jmp)
            lcpid_pkg::JMP_NOPID: taken = !pid_go;
            lcpid_pkg::JMP_WAIT:  taken = out_busy;
            default:              taken = 1'b0;
        endcase
        pc_next = taken ? uw.target : r_pc + lcpid_pkg::PC_W'(1);
    end

    // ---------------------------------------------------------------------
    // Control, configuration and loop state
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop    <= lcpid_pkg::GAIN_PROP_RST;
            r_gain_integ   <= lcpid_pkg::GAIN_INTEG_RST;
            r_gain_deriv   <= lcpid_pkg::GAIN_DERIV_RST;
            r_over_limit   <= lcpid_pkg::OVER_LIMIT_RST;
            r_safe_level   <= lcpid_pkg::SAFE_LEVEL_RST;
            r_ramp_step    <= lcpid_pkg::RAMP_STEP_RST;
            r_ramp_ceiling <= lcpid_pkg::RAMP_CEILING_RST;
            r_setpoint_max <= lcpid_pkg::SETPOINT_MAX_RST;
            r_level        <= lcpid_pkg::SAFE_LEVEL_RST;
            r_setpoint     <= '0;
            r_active       <= 1'b0;
            r_integ        <= '0;
            r_last_err     <= '0;
            r_pending      <= 1'b0;
            r_busy         <= 1'b0;
            r_pc           <= lcpid_pkg::PC_DIV;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (lcpid_pkg::t_cfg_idx'(i_cfg_index))
                    lcpid_pkg::CFG_GAIN_PROP:    r_gain_prop    <= i_cfg_data;
                    lcpid_pkg::CFG_GAIN_INTEG:   r_gain_integ   <= i_cfg_data;
                    lcpid_pkg::CFG_GAIN_DERIV:   r_gain_deriv   <= i_cfg_data;
                    lcpid_pkg::CFG_OVER_LIMIT:   r_over_limit   <= i_cfg_data;
                    lcpid_pkg::CFG_SAFE_LEVEL:   r_safe_level   <= i_cfg_data;
                    lcpid_pkg::CFG_RAMP_STEP:    r_ramp_step    <= i_cfg_data[9:0];
                    lcpid_pkg::CFG_RAMP_CEILING: r_ramp_ceiling <= i_cfg_data;
                    lcpid_pkg::CFG_SETPOINT_MAX: r_setpoint_max <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // a new result may replace one taken in the same cycle
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc) begin
                r_busy     <= 1'b1;
                r_pc       <= lcpid_pkg::PC_DIV;
                r_setpoint <= sp_next;
                if (i_tick) begin
                    r_pending <= 1'b1;
                end
            end else if (r_busy) begin
                r_pc <= pc_next;
                case (uw.op)
                    lcpid_pkg::UOP_EVAL: begin
                        if (over) begin
                            // tick stays pending
                            r_level <= safe_clamp;
                        end else if (r_pending) begin
                            r_pending <= 1'b0;
                            if (r_active) begin
                                r_last_err <= eval_err;
                                r_integ    <= integ_sat;
                            end else begin
                                if (amps > sp_q13) begin
                                    r_active <= 1'b1;
                                end
                                r_integ <= '0;
                                if (r_level < r_ramp_ceiling) begin
                                    r_level <= ramp_clamp;
                                end
                            end
                        end
                    end
                    lcpid_pkg::UOP_FIN: begin
                        r_level <= fin_level;
                        if (r_integ < DROP_LIM) begin
                            r_active <= 1'b0;
                            r_integ  <= '0;
                        end
                    end
                    lcpid_pkg::UOP_OUT: begin
                        if (!out_busy) begin
                            r_busy <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath registers (no reset)
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_num <= num;
        end else if (r_busy) begin
            case (uw.op)
                lcpid_pkg::UOP_DIV: begin
                    r_quo <= quo_est;
                end
                lcpid_pkg::UOP_DIVFIX: begin
                    r_quo <= quo_fix;
                end
                lcpid_pkg::UOP_SPMUL: begin
                    r_prod <= mul_p;
                end
                lcpid_pkg::UOP_EVAL: begin
                    r_over <= over;
                    r_prev <= r_last_err;
                end
                lcpid_pkg::UOP_MUL_P: begin
                    r_prod <= mul_p;
                end
                lcpid_pkg::UOP_MUL_I: begin
                    r_prod <= mul_p;
                    r_acc  <= ACC_W'(r_prod);
                end
                lcpid_pkg::UOP_MUL_D: begin
                    r_prod <= mul_p;
                    r_acc  <= r_acc + ACC_W'(r_prod);
                end
                lcpid_pkg::UOP_ACC: begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                lcpid_pkg::UOP_OUT: begin
                    if (!out_busy) begin
                        r_out_level    <= r_level;
                        r_out_setpoint <= r_setpoint;
                        r_out_active   <= r_active;
                        r_out_over     <= r_over;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= lcpid_pkg::PC_OUT))
        else $error("micro-address beyond program");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid &&
            $stable({o_drive_level, o_setpoint_now, o_regulating, o_overcurrent})))
        else $error("waiting result item changed or dropped");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_busy && r_pc == lcpid_pkg::PC_DIV))
        else $error("accepted item did not start the program");

    a_integ_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_integ == '0))
        else $error("integral non-zero outside PID mode");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_level <= LVL_MAX))
        else $error("drive level above saturation");
`endif

endmodule

`default_nettype wire

@@ verif/lcpid_loop_checker.sv @@
// Result checker for the load current regulator: predicts every pass and compares.
module lcpid_loop_checker #(
    parameter int ADC_BITS    = lcpid_pkg::ADC_BITS_DEF,
    parameter int INTEG_WIDTH = lcpid_pkg::INTEG_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [ADC_BITS-1:0] i_current_code,
    input  logic                i_plus_press,
    input  logic                i_minus_press,
    input  logic                i_tick,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [15:0]         i_drive_level,
    input  logic [7:0]          i_setpoint_now,
    input  logic                i_regulating,
    input  logic                i_overcurrent,
    output int                  o_results_due,
    output int                  o_fail_count
);
    import lcpid_pkg::*;

    typedef struct packed {
        logic [15:0] level;
        logic [7:0]  setpoint;
        logic        regulating;
        logic        over;
    } t_loop_result;

    localparam longint ADC_FULL   = (longint'(1) << ADC_BITS) - 1;
    localparam longint AMPS_SCALE = 270336;     // 3.3 * 8192 * 10
    localparam longint INTEG_MAX  = (longint'(1) << (INTEG_WIDTH - 1)) - 1;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;
    localparam longint HALF_LSB   = 16384;      // Q.29 -> Q2.14 round half up

    // register copies
    logic [15:0] gain_p, gain_i, gain_d, over_limit, safe_lvl, ramp_ceiling;
    logic [9:0]  ramp_inc;
    logic [7:0]  setpoint_cap;

    // loop state
    logic [15:0] level_q14;
    logic [7:0]  setpoint_units;
    logic        pid_on;
    longint      integ_q13;
    longint      last_err_q13;
    logic        tick_waiting;

    t_loop_result due_results[$];
    int           failures = 0;

    assign o_fail_count = failures;

    function automatic logic [15:0] clamp_level(input longint v);
        if (v < 0) return 16'd0;
        if (v > LEVEL_MAX) return 16'(LEVEL_MAX);
        return v[15:0];
    endfunction

    // one pass of the control loop; updates the loop state
    function automatic t_loop_result regulate_pass(input logic [ADC_BITS-1:0] code,
            input logic plus, input logic minus, input logic tick);
        t_loop_result r;
        longint amps, sp_q13, err, prev, pid_sum;
        logic over;
        amps = ((longint'(code) + 1) * AMPS_SCALE + 5 * ADC_FULL) / (10 * ADC_FULL);
        if (plus && setpoint_units <= setpoint_cap && setpoint_units != 8'hFF)
            setpoint_units = setpoint_units + 8'd1;
        if (minus && setpoint_units > 8'd1)
            setpoint_units = setpoint_units - 8'd1;
        if (tick)
            tick_waiting = 1'b1;
        over = amps > longint'(over_limit);
        if (over) begin
            level_q14 = clamp_level(longint'(safe_lvl));
        end else if (tick_waiting) begin
            sp_q13 = (longint'(setpoint_units) * 8192 + 50) / 100;
            if (pid_on) begin
                prev         = last_err_q13;
                err          = amps - sp_q13;
                last_err_q13 = err;
                integ_q13    = integ_q13 + err;
                if (integ_q13 > INTEG_MAX) integ_q13 = INTEG_MAX;
                if (integ_q13 < INTEG_MIN) integ_q13 = INTEG_MIN;
                pid_sum = err * longint'(gain_p) + integ_q13 * longint'(gain_i)
                        + (prev - err) * longint'(gain_d);
                level_q14 = clamp_level(((longint'(level_q14) <<< 15) - pid_sum
                                         + HALF_LSB) >>> 15);
                if (integ_q13 < DROPOUT_LIMIT) begin
                    pid_on    = 1'b0;
                    integ_q13 = 0;
                end
            end else begin
                if (amps > sp_q13) pid_on = 1'b1;
                integ_q13 = 0;
                if (level_q14 < ramp_ceiling)
                    level_q14 = clamp_level(longint'(level_q14) + longint'(ramp_inc));
            end
            tick_waiting = 1'b0;
        end
        r.level      = level_q14;
        r.setpoint   = setpoint_units;
        r.regulating = pid_on;
        r.over       = over;
        return r;
    endfunction

    function automatic void note_failure(input string what);
        if (failures < 10) $display("[%0t] result error: %s", $realtime, what);
        failures++;
    endfunction

    always @(posedge i_clk) begin
        t_loop_result got, want;
        if (!i_rst_n) begin
            gain_p         = GAIN_PROP_RST;
            gain_i         = GAIN_INTEG_RST;
            gain_d         = GAIN_DERIV_RST;
            over_limit     = OVER_LIMIT_RST;
            safe_lvl       = SAFE_LEVEL_RST;
            ramp_inc       = RAMP_STEP_RST;
            ramp_ceiling   = RAMP_CEILING_RST;
            setpoint_cap   = SETPOINT_MAX_RST;
            level_q14      = SAFE_LEVEL_RST;
            setpoint_units = 8'd0;
            pid_on         = 1'b0;
            integ_q13      = 0;
            last_err_q13   = 0;
            tick_waiting   = 1'b0;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_PROP:    gain_p       = i_cfg_data;
                    CFG_GAIN_INTEG:   gain_i       = i_cfg_data;
                    CFG_GAIN_DERIV:   gain_d       = i_cfg_data;
                    CFG_OVER_LIMIT:   over_limit   = i_cfg_data;
                    CFG_SAFE_LEVEL:   safe_lvl     = i_cfg_data;
                    CFG_RAMP_STEP:    ramp_inc     = i_cfg_data[9:0];
                    CFG_RAMP_CEILING: ramp_ceiling = i_cfg_data;
                    CFG_SETPOINT_MAX: setpoint_cap = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // a result leaving now belongs to an earlier item, so compare first
            if (i_out_valid && i_out_ready) begin
                got = '{i_drive_level, i_setpoint_now, i_regulating, i_overcurrent};
                if (due_results.size() == 0) begin
                    note_failure($sformatf("unexpected item level %0d sp %0d reg %0b oc %0b",
                        got.level, got.setpoint, got.regulating, got.over));
                end else begin
                    want = due_results.pop_front();
                    if (got !== want)
                        note_failure($sformatf(
                            "level %0d/%0d sp %0d/%0d reg %0b/%0b oc %0b/%0b (exp/act)",
                            want.level, got.level, want.setpoint, got.setpoint,
                            want.regulating, got.regulating, want.over, got.over));
                end
            end
            if (i_in_valid && i_in_ready)
                due_results.push_back(regulate_pass(i_current_code, i_plus_press,
                                                    i_minus_press, i_tick));
        end
        o_results_due <= due_results.size();
    end

endmodule

@@ verif/load_current_pid_regulator_core_test.sv @@
// Stimulus and verdict for the load current regulator core.
module load_current_pid_regulator_core_test;
    import lcpid_pkg::*;

    localparam int ADC_BITS         = ADC_BITS_DEF;
    localparam int CODE_TOP         = (1 << ADC_BITS) - 1;
    localparam int CYCLE_LIMIT      = 400000;   // far above the slowest legal run
    localparam int LONG_HOLD_CYCLES = 300;      // receiver back-pressure stretch
    localparam int TAIL_CYCLES      = 60;       // > one full PID pass plus output slot

    // Shapes of random loop traffic
    typedef enum {
        MODE_WALK,      // current drifts slowly, light button use
        MODE_CLIMB,     // mostly plus presses, drives setpoint into its ceiling
        MODE_SATURATE   // high current, tick on almost every pass: winds the integral up
    } t_traffic;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            cfg_valid   = 1'b0;
    logic            cfg_ready;
    t_cfg_idx        cfg_index   = CFG_GAIN_PROP;
    logic [15:0]     cfg_data    = '0;
    logic            in_valid    = 1'b0;
    logic            in_ready;
    logic [ADC_BITS-1:0] current_code = '0;
    logic            plus_press  = 1'b0;
    logic            minus_press = 1'b0;
    logic            tick        = 1'b0;
    logic            out_valid;
    logic            out_ready   = 1'b0;
    logic [15:0]     drive_level;
    logic [7:0]      setpoint_now;
    logic            regulating;
    logic            overcurrent;

    int              results_due;
    int              fail_count;
    int unsigned     cycle_count   = 0;
    int              send_idle_pct = 0;
    int              code_walk     = 0;
    bit              calm          = 1'b0;  // final stretch: no idling on either side
    bit              sink_hold_req = 1'b0;  // asks the receiver for one long stall

    always #5 clk = ~clk;

    load_current_pid_regulator_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_current_code (current_code),
        .i_plus_press   (plus_press),
        .i_minus_press  (minus_press),
        .i_tick         (tick),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_drive_level  (drive_level),
        .o_setpoint_now (setpoint_now),
        .o_regulating   (regulating),
        .o_overcurrent  (overcurrent)
    );

    // Watches all three channels, predicts each pass and compares
    lcpid_loop_checker #(.ADC_BITS(ADC_BITS)) loop_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_current_code (current_code),
        .i_plus_press   (plus_press),
        .i_minus_press  (minus_press),
        .i_tick         (tick),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_drive_level  (drive_level),
        .i_setpoint_now (setpoint_now),
        .i_regulating   (regulating),
        .i_overcurrent  (overcurrent),
        .o_results_due  (results_due),
        .o_fail_count   (fail_count)
    );

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result receiver. Random stall bursts at a rate that is re-drawn now and then
    // (zero included, so there are clean stretches too), plus one long hold-off
    // on request so the core backs up and drops in_ready.
    initial begin : result_sink
        int sink_idle_pct;
        bit held;
        sink_idle_pct = 10;
        held          = 1'b0;
        forever begin
            @(posedge clk);
            if (sink_hold_req && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 63) == 0) begin
                    case ($urandom_range(0, 2))
                        0: sink_idle_pct = 0;
                        1: sink_idle_pct = 8;
                        default: sink_idle_pct = 30;
                    endcase
                end
            end
        end
    end

    // Offers one pass. Valid is only lowered when an idle gap is taken, so a
    // back-to-back item never sees valid dropped and raised in the same step.
    task automatic offer_pass(input logic [ADC_BITS-1:0] code, input logic plus,
                              input logic minus, input logic tk);
        if (!calm && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        current_code <= code;
        plus_press   <= plus;
        minus_press  <= minus;
        tick         <= tk;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait for every predicted result to come back. The
    // count is registered in the checker, hence the edge before the first look.
    task automatic await_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Full register set; only ever called with the core idle
    task automatic program_regs(input logic [15:0] gp, input logic [15:0] gi,
                                input logic [15:0] gd, input logic [15:0] over_lim,
                                input logic [15:0] safe, input logic [15:0] step,
                                input logic [15:0] ceiling, input logic [15:0] sp_cap);
        write_reg(CFG_GAIN_PROP,    gp);
        write_reg(CFG_GAIN_INTEG,   gi);
        write_reg(CFG_GAIN_DERIV,   gd);
        write_reg(CFG_OVER_LIMIT,   over_lim);
        write_reg(CFG_SAFE_LEVEL,   safe);
        write_reg(CFG_RAMP_STEP,    step);
        write_reg(CFG_RAMP_CEILING, ceiling);
        write_reg(CFG_SETPOINT_MAX, sp_cap);
        cfg_valid <= 1'b0;
    endtask

    // Random loop traffic. Mostly a slowly drifting current so the loop gets
    // through ramp, arming, PID and dropout; the odd sample drawn over the full scale is noise.
    task automatic run_phase(input int items, input t_traffic shape, input int walk_top);
        logic [ADC_BITS-1:0] code;
        logic plus, minus, tk;
        for (int k = 0; k < items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 10;
                    default: send_idle_pct = 30;
                endcase
            end
            code_walk = code_walk + int'($urandom_range(0, 96)) - 48;
            if (code_walk < 0) code_walk = 0;
            if (code_walk > walk_top) code_walk = walk_top;
            code = ADC_BITS'(code_walk);
            if ($urandom_range(0, 7) == 0) code = ADC_BITS'($urandom_range(0, CODE_TOP));
            case (shape)
                MODE_CLIMB: begin
                    plus  = $urandom_range(0, 99) < 85;
                    minus = $urandom_range(0, 99) < 10;
                    tk    = $urandom_range(0, 99) < 60;
                end
                MODE_SATURATE: begin
                    // setpoint walked down to its floor, current near full scale
                    if ($urandom_range(0, 9) != 0)
                        code = ADC_BITS'($urandom_range(CODE_TOP - 127, CODE_TOP));
                    plus  = $urandom_range(0, 99) < 5;
                    minus = 1'b1;
                    tk    = $urandom_range(0, 99) < 95;
                end
                default: begin
                    plus  = $urandom_range(0, 99) < 15;
                    minus = $urandom_range(0, 99) < 12;
                    tk    = $urandom_range(0, 99) < 50;
                end
            endcase
            offer_pass(code, plus, minus, tk);
        end
    endtask

    initial begin : stimulus
        // synchronous reset, applied once
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed passes on reset register values, setpoint starting at zero
        send_idle_pct = 0;
        offer_pass(0, 1'b0, 1'b1, 1'b0);            // minus with setpoint at the bottom
        offer_pass(0, 1'b1, 1'b1, 1'b0);            // plus and minus together
        offer_pass(0, 1'b1, 1'b1, 1'b0);
        offer_pass(0, 1'b1, 1'b0, 1'b0);
        offer_pass(0, 1'b1, 1'b0, 1'b1);            // tick below setpoint: ramp only
        offer_pass(CODE_TOP, 1'b0, 1'b0, 1'b0);     // overcurrent forces safe level
        offer_pass(CODE_TOP, 1'b0, 1'b0, 1'b1);     // tick held back by overcurrent
        offer_pass(1488, 1'b0, 1'b0, 1'b0);         // exactly at the limit: held tick arms
        offer_pass(1489, 1'b0, 1'b0, 1'b1);         // one code above the limit
        offer_pass(1488, 1'b0, 1'b0, 1'b1);         // first PID update, large error
        repeat (4) offer_pass(0, 1'b1, 1'b0, 1'b1); // PID with error going negative
        offer_pass(CODE_TOP, 1'b1, 1'b1, 1'b1);     // every field bit high
        offer_pass(2048, 1'b0, 1'b0, 1'b1);
        offer_pass(1, 1'b0, 1'b0, 1'b1);
        offer_pass(CODE_TOP - 1, 1'b0, 1'b1, 1'b0);
        await_idle();

        // Nominal tuning. Part way through the receiver holds off for a long
        // stretch while items keep coming, then the sender drains completely.
        program_regs(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST, OVER_LIMIT_RST,
                     SAFE_LEVEL_RST, 16'(RAMP_STEP_RST), RAMP_CEILING_RST,
                     16'(SETPOINT_MAX_RST));
        run_phase(60, MODE_WALK, 1600);
        sink_hold_req = 1'b1;
        run_phase(90, MODE_WALK, 1600);
        await_idle();
        run_phase(150, MODE_WALK, CODE_TOP);
        await_idle();

        // Everything at its top value; setpoint pushed into its 255 ceiling
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'(LEVEL_MAX), 16'h03FF,
                     16'(LEVEL_MAX), 16'h00FF);
        run_phase(300, MODE_CLIMB, CODE_TOP);
        await_idle();

        // Everything zero: every sample is an overcurrent at a zero safe level
        program_regs('0, '0, '0, '0, '0, '0, '0, '0);
        run_phase(60, MODE_WALK, CODE_TOP);
        await_idle();

        // No overcurrent, long positive error: integral runs into its clamp
        program_regs(16'd100, 16'd1, 16'd50, 16'hFFFF, 16'd3768, 16'd1023,
                     16'(LEVEL_MAX), 16'h00FF);
        run_phase(450, MODE_SATURATE, CODE_TOP);
        await_idle();

        // Random registers, out-of-range levels allowed; no idling from here on
        program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(6000, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        calm = 1'b1;
        run_phase(150, MODE_WALK, 2000);
        await_idle();

        // let any stray extra result show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
